// ----- design/fcsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsr_pkg
// Shared types and constants for the fan curve / stall restart controller.
// ----------------------------------------------------------------------------
package fcsr_pkg;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [11:0] temp_q8_4;
    logic [15:0] fan_rpm;
  } in_word_t;

  typedef struct packed {
    logic [6:0] duty_percent;
    logic [1:0] fan_mode;
    logic [6:0] target_percent;
  } out_word_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_STALL = 2'd1,
    MODE_START = 2'd2,
    MODE_ON    = 2'd3
  } fan_mode_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_CURVE_REGS = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_STARTUP_MS    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STALL_WAIT_MS = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_STALL_RPM     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_BOOST_LIMIT   = 3'd7;

  localparam logic [NUM_CURVE_REGS-1:0][15:0] CURVE_DEFAULT =
    {16'd14180, 16'd11590, 16'd9000, 16'd6420};
  localparam logic [15:0] STARTUP_MS_RST    = 16'd500;
  localparam logic [15:0] STALL_WAIT_MS_RST = 16'd1000;
  localparam logic [15:0] STALL_RPM_RST     = 16'd300;
  localparam logic [6:0]  BOOST_LIMIT_RST   = 7'd10;

  localparam logic [6:0] PCT_FULL       = 7'd100;
  localparam logic [6:0] PCT_STEP       = 7'd10;
  localparam logic [6:0] PCT_NO_SEGMENT = 7'd97;

  // interpolation datapath widths
  localparam int DEN_W      = 12;
  localparam int DIVIDEND_W = 22;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  typedef struct packed {
    logic [15:0] startup_ms;
    logic [15:0] stall_wait_ms;
    logic [15:0] stall_rpm;
    logic [6:0]  boost_limit;
  } timing_cfg_t;

  typedef struct packed {
    logic      capture;
    logic      lookup_en;
    logic      sum_en;
    logic      div_start;
    logic      commit;
    fan_mode_t mode;
    logic      entering;
    fan_mode_t next_mode;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic lookup_zero;
    logic timer_done;
    logic rpm_low;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- design/fan_curve_stall_restart_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fan_curve_stall_restart_controller
// Temperature-curve fan controller with start kick and stall restart.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per tick (timestamp in ms, Q8.4 temperature, fan rpm),
//           valid/ready handshake.
//   out_* : one word per input word (duty, mode after the tick, target),
//           valid/ready handshake, held in an output register.
//   cfg_* : write-only register port, written while no tick is in flight.
// Timing: a word accepted on the input passes the lookup, sum, divide and
//   commit steps before its result shows on out_valid. The interpolation
//   divide (one quotient bit per cycle) sets most of this. in_ready returns at
//   the edge that loads the result, so no new word is taken until then.
// Reset (rst_n low, synchronous): mode off with no entry action pending,
//   duty/target/timer cleared, config registers back to their defaults.
// Receiver stall: the finished word waits in the output register while the
//   next input word is accepted and worked on; that word's result is held
//   back until the output register is free.
// ----------------------------------------------------------------------------
module fan_curve_stall_restart_controller
  import fcsr_pkg::*;
#(
  parameter int CURVE_POINTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CURVE_POINTS-1:0][15:0] curve;
  timing_cfg_t                   timing;
  dp_cmd_t                       cmd;
  dp_status_t                    status;

  fcsr_cfg #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .curve     (curve),
    .timing    (timing)
  );

  fcsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  fcsr_datapath #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .curve     (curve),
    .timing    (timing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- design/fcsr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsr_cfg
// Configuration register file: curve points and timing / stall settings.
// ----------------------------------------------------------------------------
module fcsr_cfg
  import fcsr_pkg::*;
#(
  parameter int CURVE_POINTS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [CFG_ADDR_W-1:0]               cfg_addr,
  input  logic [CFG_DATA_W-1:0]               cfg_wdata,
  output logic [CURVE_POINTS-1:0][15:0]       curve,
  output timing_cfg_t                         timing
);

  logic [CURVE_POINTS-1:0][15:0] curve_r;
  timing_cfg_t                   timing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CURVE_POINTS; i++) begin
        curve_r[i] <= CURVE_DEFAULT[(i < NUM_CURVE_REGS) ? i : NUM_CURVE_REGS - 1];
      end
      timing_r.startup_ms    <= STARTUP_MS_RST;
      timing_r.stall_wait_ms <= STALL_WAIT_MS_RST;
      timing_r.stall_rpm     <= STALL_RPM_RST;
      timing_r.boost_limit   <= BOOST_LIMIT_RST;
    end else if (cfg_we) begin
      // points past the fourth have no register and keep their reset value
      for (int i = 0; i < CURVE_POINTS; i++) begin
        if (i < NUM_CURVE_REGS && cfg_addr == CFG_ADDR_W'(i)) begin
          curve_r[i] <= cfg_wdata;
        end
      end
      unique case (cfg_addr)
        REG_STARTUP_MS:    timing_r.startup_ms    <= cfg_wdata;
        REG_STALL_WAIT_MS: timing_r.stall_wait_ms <= cfg_wdata;
        REG_STALL_RPM:     timing_r.stall_rpm     <= cfg_wdata;
        REG_BOOST_LIMIT:   timing_r.boost_limit   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign curve  = curve_r;
  assign timing = timing_r;

endmodule
`default_nettype wire

// ----- design/fcsr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcsr_div
  import fcsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DEN_W-1:0]      divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);

  logic [DEN_W-1:0]      rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] trial;
  logic           fits;

  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits DEN_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ----- design/fcsr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsr_datapath
// Curve lookup with interpolation, timer, duty/target state, output register.
// ----------------------------------------------------------------------------
module fcsr_datapath
  import fcsr_pkg::*;
#(
  parameter int CURVE_POINTS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  input  in_word_t                      in_data,
  input  logic [CURVE_POINTS-1:0][15:0] curve,
  input  timing_cfg_t                   timing,
  output logic                          out_valid,
  input  logic                          out_ready,
  output out_word_t                     out_data
);

  in_word_t in_r;

  // ---------------- lookup stage: segment select and products
  logic [7:0]       whole;
  logic             found;
  logic [7:0]       sel_ta, sel_tb, sel_pa, sel_pb;
  logic             fixed;
  logic [6:0]       fixed_val;
  logic [DEN_W-1:0] den;
  logic [11:0]      diff;
  logic [8:0]       dp;

  assign whole = in_r.temp_q8_4[11:4];

  always_comb begin
    found  = 1'b0;
    sel_ta = '0;
    sel_tb = '0;
    sel_pa = '0;
    sel_pb = '0;
    for (int i = 0; i < CURVE_POINTS - 1; i++) begin
      if (!found && whole > curve[i][15:8] && whole <= curve[i+1][15:8]) begin
        found  = 1'b1;
        sel_ta = curve[i][15:8];
        sel_tb = curve[i+1][15:8];
        sel_pa = curve[i][7:0];
        sel_pb = curve[i+1][7:0];
      end
    end
  end

  always_comb begin
    fixed     = 1'b1;
    fixed_val = PCT_NO_SEGMENT;
    if (whole <= curve[0][15:8]) begin
      fixed_val = (curve[0][7:0] > {1'b0, PCT_FULL}) ? PCT_FULL : curve[0][6:0];
    end else if (whole > curve[CURVE_POINTS-1][15:8]) begin
      fixed_val = PCT_FULL;
    end else if (found) begin
      fixed = 1'b0;
    end
  end

  assign den  = {sel_tb - sel_ta, 4'b0000};
  assign diff = in_r.temp_q8_4 - {sel_ta, 4'b0000};
  assign dp   = {1'b0, sel_pb} - {1'b0, sel_pa};

  logic [19:0]          prod_a_r;
  logic signed [21:0]   prod_b_r;
  logic [DEN_W-1:0]     den_r;
  logic                 lk_fixed_r;
  logic [6:0]           lk_val_r;

  // ---------------- sum stage
  logic signed [22:0]    total;
  logic                  total_neg_r;
  logic [DIVIDEND_W-1:0] dividend_r;

  assign total = $signed({3'b000, prod_a_r}) + $signed({prod_b_r[21], prod_b_r});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.lookup_en) begin
      prod_a_r   <= {12'd0, sel_pa} * {8'd0, den};
      prod_b_r   <= $signed({10'd0, diff}) * $signed({{13{dp[8]}}, dp});
      den_r      <= den;
      lk_fixed_r <= fixed;
      lk_val_r   <= fixed_val;
    end
    if (cmd.sum_en) begin
      total_neg_r <= total[22];
      dividend_r  <= total[DIVIDEND_W-1:0];
    end
  end

  logic [DIVIDEND_W-1:0] quotient;
  logic                  div_done;

  fcsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend_r),
    .divisor  (den_r),
    .quotient (quotient),
    .done     (div_done)
  );

  logic [6:0] lookup;

  always_comb begin
    if (lk_fixed_r) begin
      lookup = lk_val_r;
    end else if (total_neg_r) begin
      lookup = '0;
    end else if (quotient > DIVIDEND_W'(PCT_FULL)) begin
      lookup = PCT_FULL;
    end else begin
      lookup = quotient[6:0];
    end
  end

  // ---------------- tick state
  logic [6:0]  duty_r, target_r;
  logic [31:0] ts_r;
  logic [15:0] len_r;
  logic [6:0]  duty_nxt, target_nxt;
  logic [31:0] ts_nxt;
  logic [15:0] len_nxt;
  logic [7:0]  boosted;

  assign boosted = {1'b0, target_r} + {1'b0, PCT_STEP};

  always_comb begin
    duty_nxt   = duty_r;
    target_nxt = target_r;
    ts_nxt     = ts_r;
    len_nxt    = len_r;
    unique case (cmd.mode)
      MODE_OFF: begin
        if (cmd.entering) duty_nxt = '0;
        target_nxt = lookup;
      end
      MODE_STALL: begin
        if (cmd.entering) begin
          duty_nxt = '0;
          ts_nxt   = in_r.now_ms;
          len_nxt  = timing.stall_wait_ms;
        end
        if (target_r < timing.boost_limit) begin
          target_nxt = (boosted > {1'b0, PCT_FULL}) ? PCT_FULL : boosted[6:0];
        end
      end
      MODE_START: begin
        if (cmd.entering) begin
          duty_nxt = PCT_FULL;
          ts_nxt   = in_r.now_ms;
          len_nxt  = timing.startup_ms;
        end
      end
      MODE_ON: begin
        target_nxt = lookup;
        duty_nxt   = lookup;
      end
    endcase
  end

  // timer restarted this tick has zero elapsed time
  logic [31:0] elapsed;
  assign elapsed = cmd.entering ? 32'd0 : (in_r.now_ms - ts_r);

  logic out_valid_r;
  out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r      <= '0;
      target_r    <= '0;
      ts_r        <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        duty_r      <= duty_nxt;
        target_r    <= target_nxt;
        ts_r        <= ts_nxt;
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.duty_percent   <= duty_nxt;
      out_data_r.fan_mode       <= cmd.next_mode;
      out_data_r.target_percent <= target_nxt;
    end
  end

  assign status.div_done    = div_done;
  assign status.lookup_zero = (lookup == '0);
  assign status.timer_done  = (elapsed >= {16'd0, len_nxt});
  assign status.rpm_low     = (in_r.fan_rpm < timing.stall_rpm);
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed word not presented");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.duty_percent <= PCT_FULL &&
                     out_data_r.target_percent <= PCT_FULL))
    else $error("duty or target above full scale");

endmodule
`default_nettype wire

// ----- design/fcsr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsr_ctrl
// Per-word sequencer and fan mode state machine (off / start / on / stall).
// ----------------------------------------------------------------------------
module fcsr_ctrl
  import fcsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_COMMIT
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  fan_mode_t  mode_r, prev_mode_r, mode_nxt;
  logic       commit_fire;

  assign in_ready    = (state_r == S_IDLE);
  assign commit_fire = (state_r == S_COMMIT) && status.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_LOOKUP;
      S_LOOKUP:   state_nxt = S_SUM;
      S_SUM:      state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (status.div_done) state_nxt = S_COMMIT;
      S_COMMIT:   if (status.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // stall check wins over the curve going to zero
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_OFF:   if (!status.lookup_zero) mode_nxt = MODE_START;
      MODE_STALL: if (status.timer_done) mode_nxt = MODE_START;
      MODE_START: if (status.timer_done) mode_nxt = MODE_ON;
      MODE_ON: begin
        if (status.lookup_zero) mode_nxt = MODE_OFF;
        if (status.rpm_low) mode_nxt = MODE_STALL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_OFF;
      prev_mode_r <= MODE_OFF;
    end else begin
      state_r <= state_nxt;
      if (commit_fire) begin
        prev_mode_r <= mode_r;
        mode_r      <= mode_nxt;
      end
    end
  end

  always_comb begin
    cmd.capture   = in_valid && in_ready;
    cmd.lookup_en = (state_r == S_LOOKUP);
    cmd.sum_en    = (state_r == S_SUM);
    cmd.div_start = (state_r == S_DIV_GO);
    cmd.commit    = commit_fire;
    cmd.mode      = mode_r;
    cmd.entering  = (mode_r != prev_mode_r);
    cmd.next_mode = mode_nxt;
  end

  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit_fire |=> $stable(mode_r))
    else $error("fan mode moved outside a commit");

  a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    commit_fire |=> (prev_mode_r == $past(mode_r)))
    else $error("previous mode not updated at commit");

endmodule
`default_nettype wire
